[rtl/wmf_pkg.sv]
// Shared types, constants and helpers for the 3x3 window maximum filter.
// No dependencies; imported by every rtl module of the block except wmf_ram.
`timescale 1ns / 1ps

package wmf_pkg;

  localparam int PIX_W       = 8;
  localparam int IMG_W_W     = 12;
  localparam int IMG_H_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int NUM_SLOTS   = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 12'd2048;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 16'd1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [IMG_W_W-1:0] image_width;
    logic [IMG_H_W-1:0] image_height;
  } wmf_cfg_t;

  // one new window column: rows r-2, r-1, r
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } wmf_col_t;

  // position flags of the item that carries the column
  typedef struct packed {
    logic first_col;
    logic has_x0;
    logic has_x1;
    logic has_y0;
    logic has_y1;
  } wmf_pos_t;

  function automatic pix_t max8(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

[rtl/wmf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/wmf_line_buf.sv]
// Line stores, raster counters and column assembly for the window filter.
// Depends on wmf_pkg and wmf_ram.
`timescale 1ns / 1ps

module wmf_line_buf import wmf_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic     clk,
  input  logic     rst,
  input  wmf_cfg_t cfg,
  input  logic     pixel_valid,
  output logic     pixel_ready,
  input  pix_t     pixel_in,
  output logic     col_valid,
  input  logic     col_ready,
  output wmf_col_t column,
  output wmf_pos_t pos
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_WIDTH);

  logic [CW-1:0]      col_cnt, col_cnt_next;
  logic [IMG_H_W-1:0] row_cnt, row_cnt_next;
  logic [CMPW-1:0]    width_ext, width_lim, width_m1;
  logic [IMG_H_W-1:0] height_m1;
  logic               last_col, last_row;
  logic               accept, advance;

  logic               s1_valid;
  pix_t               s1_pix;
  logic [CW-1:0]      s1_idx;
  logic               s1_row0, s1_row1;
  wmf_pos_t           s1_pos;
  logic               fwd_hit;
  logic [2*PIX_W-1:0] fwd_data;

  logic [2*PIX_W-1:0] ram_rdata, ram_wdata, line_rd;
  pix_t               upper_px, lower_px;

  // effective frame size: zero acts as one, width saturates at MAX_WIDTH
  always_comb begin
    width_ext = CMPW'(cfg.image_width);
    width_lim = (width_ext > MAX_W) ? MAX_W : width_ext;
    width_m1  = (cfg.image_width == '0) ? '0 : width_lim - CMPW'(1);
    height_m1 = (cfg.image_height == '0) ? '0 : cfg.image_height - IMG_H_W'(1);
    last_col  = CMPW'(col_cnt) >= width_m1;
    last_row  = row_cnt >= height_m1;
  end

  assign advance     = col_valid && col_ready;
  assign pixel_ready = !s1_valid || advance;
  assign accept      = pixel_valid && pixel_ready;

  always_comb begin
    col_cnt_next = col_cnt;
    row_cnt_next = row_cnt;
    if (last_col) begin
      col_cnt_next = '0;
      row_cnt_next = last_row ? '0 : row_cnt + IMG_H_W'(1);
    end else begin
      col_cnt_next = col_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt  <= col_cnt_next;
        row_cnt  <= row_cnt_next;
        s1_valid <= 1'b1;
        // read and write of the same entry at one edge: take the write data
        fwd_hit  <= advance && (s1_idx == col_cnt);
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix           <= pixel_in;
      s1_idx           <= col_cnt;
      s1_row0          <= (row_cnt == '0);
      s1_row1          <= (row_cnt == IMG_H_W'(1));
      s1_pos.first_col <= (col_cnt == '0);
      s1_pos.has_x0    <= (col_cnt != '0);
      s1_pos.has_x1    <= last_col;
      s1_pos.has_y0    <= (row_cnt != '0);
      s1_pos.has_y1    <= last_row;
      fwd_data         <= ram_wdata;
    end
  end

  // top row replicates upward: rows above row 0 read as row 0
  always_comb begin
    line_rd  = fwd_hit ? fwd_data : ram_rdata;
    lower_px = s1_row0 ? s1_pix : line_rd[PIX_W-1:0];
    upper_px = s1_row0 ? s1_pix : (s1_row1 ? lower_px : line_rd[2*PIX_W-1:PIX_W]);
  end

  assign ram_wdata  = {lower_px, s1_pix};
  assign col_valid  = s1_valid;
  assign column.top = upper_px;
  assign column.mid = lower_px;
  assign column.bot = s1_pix;
  assign pos        = s1_pos;

  // both line stores share one entry: {row r-2, row r-1}
  wmf_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (advance),
    .waddr(s1_idx),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(col_cnt),
    .rdata(ram_rdata)
  );

endmodule

[rtl/wmf_window.sv]
// 3x3 window registers, nine-way maximum and result sequencing.
// Depends on wmf_pkg.
`timescale 1ns / 1ps

module wmf_window import wmf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     col_valid,
  output logic     col_ready,
  input  wmf_col_t column,
  input  wmf_pos_t pos,
  output logic     result_valid,
  input  logic     result_ready,
  output pix_t     pixel_out,
  output logic     last_in_run,
  output logic     end_of_frame
);

  pix_t win      [3][3];
  pix_t win_next [3][3];
  pix_t new_col  [3];
  pix_t cmax0    [3];
  pix_t cmax1    [3];
  pix_t slot_val [NUM_SLOTS];
  pix_t vals     [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] mask, mask_next, mask_in, lowest, rest;
  logic                 advance, done;

  assign new_col[0] = column.top;
  assign new_col[1] = column.mid;
  assign new_col[2] = column.bot;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (pos.first_col) begin
        // left border replicates the first column
        win_next[j][0] = new_col[j];
        win_next[j][1] = new_col[j];
      end else begin
        win_next[j][0] = win[j][1];
        win_next[j][1] = win[j][2];
      end
      win_next[j][2] = new_col[j];
    end
    for (int k = 0; k < 3; k++) begin
      cmax1[k] = max8(win_next[1][k], win_next[2][k]);
      cmax0[k] = max8(win_next[0][k], cmax1[k]);
    end
    // slots: upper-left, upper-right, lower-left, lower-right
    slot_val[1] = max8(cmax0[1], cmax0[2]);
    slot_val[0] = max8(cmax0[0], slot_val[1]);
    slot_val[3] = max8(cmax1[1], cmax1[2]);
    slot_val[2] = max8(cmax1[0], slot_val[3]);
    mask_in = {pos.has_y1 & pos.has_x1, pos.has_y1 & pos.has_x0,
               pos.has_y0 & pos.has_x1, pos.has_y0 & pos.has_x0};
  end

  assign lowest       = mask & (~mask + NUM_SLOTS'(1));
  assign rest         = mask & ~lowest;
  assign result_valid = |mask;
  assign done         = result_valid && result_ready;
  assign col_ready    = (rest == '0) && (!result_valid || result_ready);
  assign advance      = col_valid && col_ready;

  always_comb begin
    mask_next = mask;
    if (advance) begin
      mask_next = mask_in;
    end else if (done) begin
      mask_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          win[j][k] <= '0;
        end
      end
    end else begin
      mask <= mask_next;
      if (advance) begin
        win <= win_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vals <= slot_val;
    end
  end

  always_comb begin
    if (mask[0]) begin
      pixel_out = vals[0];
    end else if (mask[1]) begin
      pixel_out = vals[1];
    end else if (mask[2]) begin
      pixel_out = vals[2];
    end else begin
      pixel_out = vals[3];
    end
  end

  assign last_in_run  = (rest == '0);
  assign end_of_frame = lowest[NUM_SLOTS-1];

endmodule

[rtl/window_max_filter_3x3.sv]
// Top level of the 3x3 window maximum (grayscale dilation) filter.
// Depends on wmf_pkg, wmf_line_buf, wmf_window (and wmf_ram below them).
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------------
//   pixel    | pixel_valid / pixel_ready | pixel_in[7:0]
//   result   | result_valid/result_ready | pixel_out[7:0], last_in_run, end_of_frame
//   cfg      | cfg_valid / cfg_ready     | cfg_index[0], cfg_data[15:0]
//
// One pixel transaction per cycle while each pixel yields at most one result
// and the result port is not stalled; a pixel that completes k results (up to
// four at the right column and bottom row) holds the result port for k result
// transactions. Its first result transaction follows the pixel transaction
// through the line-store read register and then the window registers.
// The line stores are one 16-bit RAM with a write and a read port; a read and
// write of the same entry at one edge is forwarded. Reset clears the counters,
// window and pipeline at once; line stores need no clearing. Result stalls
// back up through the window stage into pixel_ready; cfg_ready is always high.
`timescale 1ns / 1ps

module window_max_filter_3x3 import wmf_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  logic [PIX_W-1:0]       pixel_in,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [PIX_W-1:0]       pixel_out,
  output logic                   last_in_run,
  output logic                   end_of_frame,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  wmf_cfg_t cfg;
  logic     col_valid, col_ready;
  wmf_col_t column;
  wmf_pos_t pos;

  // user must write config only while the stream is idle (unenforced); no shadowing
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= IMAGE_WIDTH_RESET;
      cfg.image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // line stores + counters: emits one window column per pixel
  wmf_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel_in   (pixel_in),
    .col_valid  (col_valid),
    .col_ready  (col_ready),
    .column     (column),
    .pos        (pos)
  );

  // sliding window, max tree and up to four results per column
  wmf_window u_window (
    .clk         (clk),
    .rst         (rst),
    .col_valid   (col_valid),
    .col_ready   (col_ready),
    .column      (column),
    .pos         (pos),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .pixel_out   (pixel_out),
    .last_in_run (last_in_run),
    .end_of_frame(end_of_frame)
  );

endmodule

[rtl/wmf_checker.sv]
// Port-level checks for the window maximum filter, bound to the top level.
// Depends on wmf_pkg and window_max_filter_3x3.
`timescale 1ns / 1ps

module wmf_checker import wmf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             pixel_ready,
  input logic             result_valid,
  input logic             result_ready,
  input logic [PIX_W-1:0] pixel_out,
  input logic             last_in_run,
  input logic             end_of_frame
);

  // stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(pixel_out) && $stable(last_in_run) && $stable(end_of_frame))
    else $error("result changed while stalled");

  // bottom-right result is always the last of its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && end_of_frame |-> last_in_run)
    else $error("end_of_frame without last_in_run");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // pipeline is free to take a pixel right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> pixel_ready)
    else $error("pixel_ready low after reset");

endmodule

bind window_max_filter_3x3 wmf_checker u_wmf_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_ready (pixel_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .pixel_out   (pixel_out),
  .last_in_run (last_in_run),
  .end_of_frame(end_of_frame)
);

[test/tb_window_max_filter_3x3.sv]
// Self-checking testbench for window_max_filter_3x3: 3x3 max filter over a raster pixel stream.
// Depends on rtl/wmf_pkg.sv and rtl/window_max_filter_3x3.sv; a built-in predictor checks results.
`timescale 1ns / 1ps

module tb_window_max_filter_3x3;
  import wmf_pkg::*;

  localparam int          LINE_DEPTH    = 2048;
  localparam int unsigned SETTLE_CYCLES = 8;        // pipeline depth plus margin
  localparam int unsigned RANDOM_ITEMS  = 200;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;

  // One expected result transaction.
  typedef struct packed {
    pix_t value;
    logic last;
    logic eof;
  } window_peak_t;

  // Receiver backpressure patterns.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_COIN,
    READY_PERIODIC
  } ready_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   pixel_valid  = 1'b0;
  logic                   pixel_ready;
  logic [PIX_W-1:0]       pixel_in     = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic [PIX_W-1:0]       pixel_out;
  logic                   last_in_run;
  logic                   end_of_frame;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  always #2 clk = ~clk;

  window_max_filter_3x3 #(.MAX_WIDTH(LINE_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .last_in_run  (last_in_run),
    .end_of_frame (end_of_frame),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the filter's line stores, window,
  // raster counters and geometry registers.
  // ---------------------------------------------------------------------------
  logic [IMG_W_W-1:0] width_reg  = IMAGE_WIDTH_RESET;
  logic [IMG_H_W-1:0] height_reg = IMAGE_HEIGHT_RESET;
  bit   [PIX_W-1:0]   upper_row [LINE_DEPTH];   // row r-2
  bit   [PIX_W-1:0]   lower_row [LINE_DEPTH];   // row r-1
  bit   [PIX_W-1:0]   win [3][3];               // [row][column], column 2 newest
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;

  window_peak_t peaks_due[$];     // expected results, oldest first
  pix_t         pixel_queue[$];   // pixels waiting for the driver

  int unsigned cycle_count    = 0;
  int unsigned faults         = 0;
  int unsigned pixels_sent    = 0;
  int unsigned peaks_checked  = 0;
  int unsigned frames_seen    = 0;
  int unsigned cfg_writes     = 0;

  function automatic pix_t peak(pix_t x, pix_t y);
    return (x > y) ? x : y;
  endfunction

  // Advance the predictor by one accepted pixel and queue every result it
  // completes: output columns c-1 / c and rows r-1 / r, upper row first.
  function automatic void dilate_pixel(pix_t p);
    int unsigned  w, h, c, r, idx;
    pix_t         a, b;
    pix_t         colmax [2][3];
    pix_t         val [2][2];
    bit           has_y [2];
    bit           has_x [2];
    window_peak_t found [4];
    int           n;

    w = width_reg;
    h = height_reg;
    if (w == 0) w = 1;                 // zero width behaves as one
    if (w > LINE_DEPTH) w = LINE_DEPTH; // oversize width clamps to line depth
    if (h == 0) h = 1;
    c   = col_pos;
    r   = row_pos;
    idx = c % LINE_DEPTH;

    // First row replicates upward; second row reuses row r-1 for r-2.
    if (r == 0) begin
      a = p;
      b = p;
    end else begin
      b = lower_row[idx];
      a = (r == 1) ? b : upper_row[idx];
    end
    upper_row[idx] = b;
    lower_row[idx] = p;

    for (int j = 0; j < 3; j++) begin
      win[j][0] = (c == 0) ? '0 : win[j][1];
      win[j][1] = (c == 0) ? '0 : win[j][2];
    end
    win[0][2] = a;
    win[1][2] = b;
    win[2][2] = p;
    // Left edge replicates the first column across the window.
    if (c == 0) begin
      for (int j = 0; j < 3; j++) begin
        win[j][0] = win[j][2];
        win[j][1] = win[j][2];
      end
    end

    for (int k = 0; k < 3; k++) begin
      colmax[1][k] = peak(win[1][k], win[2][k]);
      colmax[0][k] = peak(win[0][k], colmax[1][k]);
    end
    for (int yi = 0; yi < 2; yi++) begin
      val[yi][1] = peak(colmax[yi][1], colmax[yi][2]);
      val[yi][0] = peak(colmax[yi][0], val[yi][1]);
    end

    has_y[0] = (r >= 1);
    has_y[1] = (r >= h - 1);
    has_x[0] = (c >= 1);
    has_x[1] = (c >= w - 1);

    n = 0;
    for (int yi = 0; yi < 2; yi++) begin
      for (int xi = 0; xi < 2; xi++) begin
        if (has_y[yi] && has_x[xi]) begin
          found[n].value = val[yi][xi];
          found[n].last  = 1'b0;
          found[n].eof   = (yi == 1 && xi == 1);
          n++;
        end
      end
    end
    if (n > 0) found[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) peaks_due.push_back(found[i]);

    if (has_x[1]) begin
      col_pos = 0;
      row_pos = has_y[1] ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: bursts of random length separated by random gaps. A gap of
  // zero chains bursts into long unbroken stretches. The prediction is taken
  // at the edge where the transaction completes.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 16;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) begin
        dilate_pixel(pixel_in);
        pixels_sent++;
      end
      // Slot is free unless a transaction is still waiting for ready.
      if (!pixel_valid || pixel_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          pixel_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          pixel_valid <= 1'b1;
          pixel_in    <= pixel_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: ready follows a randomly picked pattern that is changed when
  // its run ends, including long always-ready stretches.
  // ---------------------------------------------------------------------------
  ready_mode_e ready_mode = READY_ALWAYS;
  int unsigned mode_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        READY_ALWAYS: begin
          result_ready <= 1'b1;
        end
        READY_MOSTLY: begin
          result_ready <= ($urandom_range(0, 3) != 0);
        end
        READY_COIN: begin
          result_ready <= ($urandom_range(0, 1) != 0);
        end
        default: begin
          result_ready <= ((cycle_count % 7) > 2);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each completed result transaction is compared with the
  // oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    window_peak_t want;
    if (!rst && result_valid && result_ready) begin
      if (peaks_due.size() == 0) begin
        $error("unexpected result transaction: pixel_out %0d", pixel_out);
        faults++;
      end else begin
        want = peaks_due.pop_front();
        if (pixel_out !== want.value) begin
          $error("pixel_out: expected %0d, actual %0d", want.value, pixel_out);
          faults++;
        end
        if (last_in_run !== want.last) begin
          $error("last_in_run: expected %0b, actual %0b", want.last, last_in_run);
          faults++;
        end
        if (end_of_frame !== want.eof) begin
          $error("end_of_frame: expected %0b, actual %0b", want.eof, end_of_frame);
          faults++;
        end
        peaks_checked++;
        if (want.eof) frames_seen++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing.
  // ---------------------------------------------------------------------------

  // Block until the sender is empty and every expected result has arrived,
  // then let the pipeline settle. Returns just after a falling edge.
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || pixel_valid || peaks_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == REG_IMAGE_WIDTH) width_reg = data[IMG_W_W-1:0];
    else height_reg = data;
    cfg_writes++;
  endtask

  // Geometry changes only between frames, with the filter idle.
  task automatic set_geometry(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, wdata);
    write_reg(REG_IMAGE_HEIGHT, hdata);
    @(negedge clk);
  endtask

  // Dense: full-range noise. Sparse: dark field with occasional bright spots,
  // so the neighbourhood maximum actually moves around.
  function automatic pix_t pick_pixel(bit sparse);
    if (sparse)
      return ($urandom_range(0, 7) == 0) ? pix_t'($urandom_range(0, 255))
                                         : pix_t'($urandom_range(0, 3));
    return pix_t'($urandom);
  endfunction

  initial begin : stimulus
    pix_t        corner_frame [9];
    pix_t        quad_frame [4];
    pix_t        column_frame [3];
    pix_t        row_frame [4];
    int unsigned random_sent;
    int unsigned w, h, ew, eh, n, cut;
    bit          sparse;
    bit          first_phase;

    corner_frame = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd17};
    quad_frame   = '{8'd1, 8'd2, 8'd3, 8'd4};
    column_frame = '{8'd9, 8'd200, 8'd3};
    row_frame    = '{8'd0, 8'd255, 8'd7, 8'd128};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-pixel frames, at the extremes of the pixel range.
    set_geometry(16'd1, 16'd1);
    pixel_queue.push_back(8'd0);
    pixel_queue.push_back(8'd255);
    // Zero width and height codes behave as a single pixel.
    set_geometry(16'd0, 16'd0);
    pixel_queue.push_back(8'h55);
    pixel_queue.push_back(8'hAA);
    // Bright corners replicated across the clamped border.
    set_geometry(16'd3, 16'd3);
    foreach (corner_frame[i]) pixel_queue.push_back(corner_frame[i]);
    // Smallest frame with four results on its last pixel.
    set_geometry(16'd2, 16'd2);
    foreach (quad_frame[i]) pixel_queue.push_back(quad_frame[i]);
    // One column, then one row.
    set_geometry(16'd1, 16'd3);
    foreach (column_frame[i]) pixel_queue.push_back(column_frame[i]);
    set_geometry(16'd4, 16'd1);
    foreach (row_frame[i]) pixel_queue.push_back(row_frame[i]);

    // Random: small geometries, whole frames, now and then a mid-frame hold
    // until the filter has drained.
    random_sent = 0;
    first_phase = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      w = $urandom_range(0, 9);
      h = $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(24, 40);
        h = $urandom_range(0, 2);
      end
      if (first_phase) h = 3;
      ew = (w == 0) ? 1 : w;
      eh = (h == 0) ? 1 : h;
      n  = ew * eh;
      // a second frame of the same size only while the budget allows it
      if (random_sent + 2 * n <= RANDOM_ITEMS && $urandom_range(0, 1) == 1) n = 2 * n;
      set_geometry(w[CFG_DATA_W-1:0], h[CFG_DATA_W-1:0]);
      sparse = $urandom_range(0, 1);
      cut = (first_phase || $urandom_range(0, 2) == 0) ? $urandom_range(1, n - 1) : n;
      for (int unsigned i = 0; i < n; i++) begin
        if (i == cut) wait_drained();
        pixel_queue.push_back(pick_pixel(sparse));
      end
      random_sent += n;
      first_phase = 1'b0;
    end

    // Width codes above 12 bits keep only their low bits; zero low bits act as one.
    set_geometry(16'h1003, 16'd2);
    repeat (6) pixel_queue.push_back(pick_pixel(1'b0));
    set_geometry(16'hF000, 16'd2);
    repeat (2) pixel_queue.push_back(pick_pixel(1'b0));

    // Oversize width code that clamps; the run ends partway into this row.
    set_geometry(16'hFFFF, 16'd1);
    repeat (40) pixel_queue.push_back(pick_pixel(1'b1));

    wait_drained();

    $display("Covered %0d pixel transactions, %0d results checked, %0d complete frames.",
             pixels_sent, peaks_checked, frames_seen);
    $display("Geometry: %0d register writes, 1x1 up to 40 wide, zero, truncated and oversize codes.",
             cfg_writes);
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[window_max_filter_3x3.f]
rtl/wmf_pkg.sv
rtl/wmf_ram.sv
rtl/wmf_line_buf.sv
rtl/wmf_window.sv
rtl/window_max_filter_3x3.sv
rtl/wmf_checker.sv
test/tb_window_max_filter_3x3.sv
